>>> design/bth_pkg.sv
// Package for the boundary-tag heap allocator: command and status codes,
// tag patterns, sequencer states and channel payload structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bth_pkg;

  localparam logic [31:0] HDR_PAT = 32'h6268_6472;
  localparam logic [31:0] TRL_PAT = 32'h6274_726c;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_SIZE  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOMEM   = 3'd1,
    ST_OUTSIDE = 3'd2,
    ST_CORRUPT = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_ZERO    = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [13:0] req_bytes;
    logic [11:0] word_index;
    logic [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] payload_index;
    logic [13:0] net_bytes;
    logic [31:0] read_value;
  } out_item_t;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE,
    S_INIT,
    S_RD,       // read issue of a raw word
    S_RDW,
    S_A_RD,     // alloc walk: read tag at p
    S_A_CHK,
    S_A_W0, S_A_W1, S_A_W2, S_A_W3, S_A_W4, S_A_W5, S_A_W6, S_A_W7,
    S_A_RT,     // whole take: read last trailer word
    S_A_RTW,
    S_SZ_RD,
    S_SZ_HD,
    S_SZ_SZ,
    S_F_HP,     // free: check header pattern
    S_F_HS,     // header size
    S_F_TP,     // own trailer pattern
    S_F_PT,     // predecessor trailer pattern
    S_F_PS,     // predecessor size
    S_F_PH,     // predecessor header pattern
    S_F_PF,     // predecessor header size
    S_F_SP,     // successor header pattern
    S_F_SS,     // successor size
    S_F_ST,     // successor trailer pattern
    S_F_OWN,    // check successor trailer pattern
    S_F_W0, S_F_W1, S_F_W2, S_F_W3, S_F_W4, S_F_W5, S_F_W6,
    S_F_NEG,    // write back the negated last trailer word
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> design/boundary_tag_heap_allocator_unit.sv
// Boundary-tag first-fit heap allocator over one heap RAM (bth_ram).
// Alloc time grows with each block walked; the other commands do not walk the heap.
// One command at a time; the next is accepted at the edge that ends the strobe.
// The single RAM port (one access per cycle, registered read) sets the rate.
// Reset: a pass writes the tags of one free block, busy high; no result stall.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_heap_allocator_unit #(
  parameter int HEAP_WORDS = 4096,
  parameter int WORD_BYTES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire bth_pkg::in_item_t   in_item,
  output logic                     out_valid,
  output bth_pkg::out_item_t       out_item
);
  import bth_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int PW = AW + 2;          // position width, room for sums
  localparam int SH = $clog2(WORD_BYTES);
  localparam logic [31:0] TOTAL = 32'(HEAP_WORDS * WORD_BYTES);
  localparam logic [PW-1:0] HW = PW'(HEAP_WORDS);

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  out_item_t        res_r, res_nxt;
  logic             ov_r, ov_nxt;
  logic [PW-1:0]    p_r, p_nxt;        // block start (alloc p, free h)
  logic [PW-1:0]    gw_r, gw_nxt;      // own block words / need words
  logic [PW-1:0]    ph_r, ph_nxt;
  logic [PW-1:0]    s_r, s_nxt;
  logic [PW-1:0]    sw_r, sw_nxt;
  logic [31:0]      v_r, v_nxt;        // tag value held
  logic [1:0]       sel_r, sel_nxt;    // {pred free, succ free}

  logic             we;
  logic [PW-1:0]    addr;
  logic [31:0]      wdata, rdata;

  bth_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_ram (
    .clk(clk), .we(we), .addr(addr[AW-1:0]), .wdata(wdata), .rdata(rdata));

  // helpers on the tag read back
  logic [31:0] mag;
  logic        rfree, malign;
  logic [31:0] words;
  logic [31:0] need_w, gross, rem;
  assign mag    = rdata[31] ? (32'd0 - rdata) : rdata;
  assign rfree  = ~rdata[31];
  assign malign = (mag & 32'(WORD_BYTES - 1)) != 32'd0;
  assign words  = mag >> SH;
  assign need_w = ((32'(item_r.req_bytes) + 32'(WORD_BYTES - 1)) >> SH) + 32'd4;
  assign gross  = need_w << SH;
  assign rem    = v_r - gross;

  // tag validity check against a room
  function automatic logic tag_ok(input logic [31:0] m, input logic [31:0] room);
    logic [31:0] w;
    w = m >> SH;
    return ((m & 32'(WORD_BYTES - 1)) == 32'd0) && (w >= 32'd4) && (w <= room);
  endfunction

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ov_r    <= 1'b0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      p_r     <= p_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    gw_r   <= gw_nxt;
    ph_r   <= ph_nxt;
    s_r    <= s_nxt;
    sw_r   <= sw_nxt;
    v_r    <= v_nxt;
    sel_r  <= sel_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = res_r;

  // sequencer
  always_comb begin
    logic [PW-1:0] w;
    logic [31:0]   sz;
    state_nxt = state_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    ov_nxt    = 1'b0;
    p_nxt     = p_r;
    gw_nxt    = gw_r;
    ph_nxt    = ph_r;
    s_nxt     = s_r;
    sw_nxt    = sw_r;
    v_nxt     = v_r;
    sel_nxt   = sel_r;
    we        = 1'b0;
    addr      = '0;
    wdata     = '0;
    w         = PW'(item_r.word_index);
    sz        = '0;

    unique case (state_r)
      // reset pass writes the four tags, p_r counts
      S_INIT: begin
        we = 1'b1;
        unique case (p_r[1:0])
          2'd0: begin addr = '0; wdata = TOTAL; end
          2'd1: begin addr = PW'(1); wdata = HDR_PAT; end
          2'd2: begin addr = HW - PW'(2); wdata = TRL_PAT; end
          default: begin addr = HW - PW'(1); wdata = TOTAL; end
        endcase
        p_nxt = p_r + PW'(1);
        if (p_r[1:0] == 2'd3) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (start) begin
          item_nxt = in_item;
          res_nxt  = '0;
          w        = PW'(in_item.word_index);
          unique case (in_item.cmd) inside
            CMD_ALLOC: begin
              p_nxt = '0;
              if (in_item.req_bytes == '0) begin
                res_nxt.status = ST_ZERO; state_nxt = S_DONE;
              end else state_nxt = S_A_RD;
            end
            CMD_FREE, CMD_SIZE: begin
              if (w >= HW || w < PW'(2)) begin
                res_nxt.status = ST_OUTSIDE; state_nxt = S_DONE;
              end else if (in_item.cmd == CMD_SIZE) begin
                state_nxt = S_SZ_RD;
              end else begin
                p_nxt = w - PW'(2);
                state_nxt = S_F_HP;
              end
            end
            CMD_WRITE: begin
              if (w >= HW) res_nxt.status = ST_OUTSIDE;
              else begin
                we = 1'b1; addr = w; wdata = in_item.write_value;
              end
              state_nxt = S_DONE;
            end
            CMD_READ: begin
              if (w >= HW) begin
                res_nxt.status = ST_OUTSIDE; state_nxt = S_DONE;
              end else state_nxt = S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_RD:  begin addr = w; state_nxt = S_RDW; end
      S_RDW: begin res_nxt.read_value = rdata; state_nxt = S_DONE; end

      // size query: header pattern then size
      S_SZ_RD: begin addr = w - PW'(1); state_nxt = S_SZ_HD; end
      S_SZ_HD: begin
        if (rdata != HDR_PAT) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          addr = w - PW'(2); state_nxt = S_SZ_SZ;
        end
      end
      S_SZ_SZ: begin
        if (mag <= 32'(4 * WORD_BYTES)) res_nxt.net_bytes = '0;
        else if (mag - 32'(4 * WORD_BYTES) > 32'd16383) res_nxt.net_bytes = 14'h3fff;
        else res_nxt.net_bytes = 14'(mag - 32'(4 * WORD_BYTES));
        state_nxt = S_DONE;
      end

      // alloc walk
      S_A_RD: begin
        if (p_r >= HW) begin
          res_nxt.status = ST_NOMEM; state_nxt = S_DONE;
        end else begin
          addr = p_r; state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        v_nxt  = rdata;
        gw_nxt = PW'(need_w);
        if (rfree && rdata >= gross) begin
          if (malign || (words > 32'(HW - p_r))) begin
            res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
          end else begin
            sw_nxt = PW'(words);  // block words
            state_nxt = S_A_W0;
          end
        end else if (mag == '0 || malign) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else if (words >= 32'(HW - p_r)) begin
          res_nxt.status = ST_NOMEM; state_nxt = S_DONE;
        end else begin
          p_nxt = p_r + PW'(words); state_nxt = S_A_RD;
        end
      end
      S_A_W0: begin
        we = 1'b1; addr = p_r;
        wdata = (rem >= 32'(5 * WORD_BYTES)) ? (32'd0 - gross) : (32'd0 - v_r);
        res_nxt.payload_index = 12'(p_r + PW'(2));
        state_nxt = S_A_W1;
      end
      S_A_W1: begin
        we = 1'b1; addr = p_r + PW'(1); wdata = HDR_PAT;
        state_nxt = (rem >= 32'(5 * WORD_BYTES)) ? S_A_W2 : S_A_W6;
      end
      S_A_W2: begin we = 1'b1; addr = p_r + gw_r - PW'(2); wdata = TRL_PAT; state_nxt = S_A_W3; end
      S_A_W3: begin we = 1'b1; addr = p_r + gw_r - PW'(1); wdata = 32'd0 - gross; state_nxt = S_A_W4; end
      S_A_W4: begin we = 1'b1; addr = p_r + gw_r; wdata = rem; state_nxt = S_A_W5; end
      S_A_W5: begin we = 1'b1; addr = p_r + gw_r + PW'(1); wdata = HDR_PAT; state_nxt = S_A_W7; end
      S_A_W7: begin we = 1'b1; addr = p_r + sw_r - PW'(2); wdata = TRL_PAT; state_nxt = S_A_RTW; end
      S_A_RTW: begin we = 1'b1; addr = p_r + sw_r - PW'(1); wdata = rem; state_nxt = S_DONE; end
      // whole-block take
      S_A_W6: begin we = 1'b1; addr = p_r + sw_r - PW'(2); wdata = TRL_PAT; state_nxt = S_A_RT; end
      S_A_RT: begin addr = p_r + sw_r - PW'(1); state_nxt = S_F_NEG; end

      // free: validation reads, p_r holds h
      S_F_HP: begin addr = p_r + PW'(1); state_nxt = S_F_HS; end
      S_F_HS: begin
        if (rdata != HDR_PAT) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          addr = p_r; state_nxt = S_F_TP;
        end
      end
      S_F_TP: begin
        v_nxt = rdata;
        if (rfree) begin
          res_nxt.status = ST_DOUBLE; state_nxt = S_DONE;
        end else if (!tag_ok(mag, 32'(HW - p_r))) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          gw_nxt = PW'(words);
          addr = p_r + PW'(words) - PW'(2);
          state_nxt = S_F_PT;
        end
      end
      S_F_PT: begin
        sel_nxt = 2'b00;
        s_nxt = p_r + gw_r;
        if (rdata != TRL_PAT) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else if (p_r >= PW'(2)) begin
          addr = p_r - PW'(2); state_nxt = S_F_PS;
        end else begin
          addr = p_r + gw_r + PW'(1); state_nxt = S_F_SS;
          if (p_r + gw_r + PW'(2) > HW) state_nxt = S_F_OWN;
        end
      end
      S_F_PS: begin
        if (rdata != TRL_PAT) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          addr = p_r - PW'(1); state_nxt = S_F_PH;
        end
      end
      S_F_PH: begin
        if (!tag_ok(mag, 32'(p_r))) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          ph_nxt = p_r - PW'(words);
          addr = p_r - PW'(words) + PW'(1);
          state_nxt = S_F_PF;
        end
      end
      S_F_PF: begin
        if (rdata != HDR_PAT) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          addr = ph_r; state_nxt = S_F_SP;
        end
      end
      S_F_SP: begin
        sel_nxt[1] = rfree;
        if (s_r + PW'(2) <= HW) begin
          addr = s_r + PW'(1); state_nxt = S_F_SS;
        end else state_nxt = S_F_OWN;
      end
      S_F_SS: begin
        if (rdata != HDR_PAT) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          addr = s_r; state_nxt = S_F_ST;
        end
      end
      S_F_ST: begin
        if (!tag_ok(mag, 32'(HW - s_r))) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          sel_nxt[0] = rfree;
          sw_nxt = PW'(words);
          addr = s_r + PW'(words) - PW'(2);
          state_nxt = S_F_OWN;
        end
      end
      S_F_OWN: begin
        // successor trailer check when the successor lies inside the heap
        if (s_r + PW'(2) <= HW && rdata != TRL_PAT) begin
          res_nxt.status = ST_CORRUPT; state_nxt = S_DONE;
        end else begin
          state_nxt = S_F_W0;
        end
      end
      // writes by merge case
      S_F_W0: begin
        unique case (sel_r)
          2'b00: begin we = 1'b1; addr = p_r; wdata = 32'd0 - v_r; state_nxt = S_F_W4; end
          2'b01: begin
            sz = 32'(s_r + sw_r - p_r) << SH;
            we = 1'b1; addr = p_r; wdata = sz; state_nxt = S_F_W1;
          end
          default: begin
            we = 1'b1; addr = ph_r;
            wdata = (sel_r[0] ? 32'(s_r + sw_r - ph_r) : 32'(p_r + gw_r - ph_r)) << SH;
            state_nxt = S_F_W1;
          end
        endcase
      end
      S_F_W1: begin
        we = 1'b1; wdata = '0;
        addr = sel_r[1] ? p_r - PW'(2) : p_r + gw_r - PW'(2);
        state_nxt = S_F_W2;
      end
      S_F_W2: begin
        we = 1'b1; wdata = '0;
        addr = sel_r[1] ? p_r + PW'(1) : s_r + PW'(1);
        state_nxt = (sel_r == 2'b11) ? S_F_W3 : S_F_W5;
      end
      // both neighbors free: clear own trailer pattern and successor header pattern
      S_F_W3: begin
        we = 1'b1; wdata = '0; addr = p_r + gw_r - PW'(2);
        state_nxt = S_F_W6;
      end
      S_F_W6: begin
        we = 1'b1; wdata = '0; addr = s_r + PW'(1);
        state_nxt = S_F_W5;
      end
      S_F_W4: begin
        // flip own last trailer word: read it
        addr = p_r + gw_r - PW'(1); state_nxt = S_F_NEG;
      end
      // last size word of the merged block
      S_F_W5: begin
        we = 1'b1;
        sz = sel_r[0] ? 32'(s_r + sw_r) : 32'(p_r + gw_r);
        addr = PW'(sz) - PW'(1);
        wdata = (sel_r == 2'b01) ? (32'(s_r + sw_r - p_r) << SH)
              : (sel_r[0] ? 32'(s_r + sw_r - ph_r) << SH : 32'(p_r + gw_r - ph_r) << SH);
        state_nxt = S_DONE;
      end
      // negate value just read (alloc whole take, plain free)
      S_F_NEG: begin
        we = 1'b1;
        addr  = (item_r.cmd == CMD_ALLOC) ? p_r + sw_r - PW'(1) : p_r + gw_r - PW'(1);
        wdata = 32'd0 - rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin ov_nxt = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> design/bth_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Testbench for boundary_tag_heap_allocator_unit: directed and random commands
// checked against a heap predictor kept in the bench. Depends on bth_pkg.
`timescale 1ns / 1ps
module testbench;
  import bth_pkg::*;

  localparam int NWORDS    = 4096;
  localparam int WBYTES    = 4;
  localparam int CYC_LIMIT = 5000000;
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  always #1 clk = ~clk;

  boundary_tag_heap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Predicted heap contents and which words hold a defined value
  logic [31:0] heap_mem [NWORDS];
  bit          heap_set [NWORDS];
  logic [31:0] snap_mem [NWORDS];
  bit          snap_set [NWORDS];
  bit          blank_read;

  out_item_t   pending_q[$];
  logic [11:0] live_q[$];
  logic [11:0] freed_q[$];
  int          err_count = 0;
  int          cycles = 0;
  int          sent_count = 0;
  int          status_seen [8];

  function automatic logic [31:0] hrd(longint i);
    if (!heap_set[i]) blank_read = 1'b1;
    return heap_mem[i];
  endfunction

  function automatic void hwr(longint i, logic [31:0] v);
    heap_mem[i] = v;
    heap_set[i] = 1'b1;
  endfunction

  function automatic logic [31:0] tag_mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  // Tag size in words, 0 if misaligned, under four words or beyond room
  function automatic longint tag_len(logic [31:0] v, longint room);
    logic [31:0] m;
    longint w;
    m = tag_mag(v);
    if (m % WBYTES != 0) return 0;
    w = m / WBYTES;
    if (w < 4 || w > room) return 0;
    return w;
  endfunction

  function automatic logic [2:0] heap_alloc(logic [13:0] req, output logic [11:0] pidx);
    longint need_w, p, bw, t;
    logic [31:0] gross, v, m, rem;
    pidx = '0;
    v = '0;
    p = 0;
    need_w = (longint'(req) + WBYTES - 1) / WBYTES + 4;
    gross = 32'(need_w * WBYTES);
    if (req == 0) return ST_ZERO;
    while (p < NWORDS) begin
      v = hrd(p);
      if (!v[31] && v >= gross) break;
      m = tag_mag(v);
      if (m == 0 || m % WBYTES != 0) return ST_CORRUPT;
      p += m / WBYTES;
    end
    if (p >= NWORDS) return ST_NOMEM;
    if (v % WBYTES != 0) return ST_CORRUPT;
    bw = v / WBYTES;
    if (bw > NWORDS - p) return ST_CORRUPT;
    rem = v - gross;
    if (rem >= 5 * WBYTES) begin
      hwr(p, -gross);
      hwr(p + 1, HDR_PAT);
      hwr(p + need_w - 2, TRL_PAT);
      hwr(p + need_w - 1, -gross);
      hwr(p + need_w, rem);
      hwr(p + need_w + 1, HDR_PAT);
      hwr(p + bw - 2, TRL_PAT);
      hwr(p + bw - 1, rem);
    end else begin
      t = p + bw - 2;
      hwr(p, -v);
      hwr(p + 1, HDR_PAT);
      hwr(t, TRL_PAT);
      hwr(t + 1, -hrd(t + 1));
    end
    pidx = 12'(p + 2);
    return ST_OK;
  endfunction

  function automatic logic [2:0] heap_free(longint w);
    longint h, gw, ph, pw, s, sw;
    bit pred_free, succ_free;
    logic [31:0] sz, tv;
    ph = 0; sw = 0; pred_free = 0; succ_free = 0;
    if (w >= NWORDS || w < 2) return ST_OUTSIDE;
    h = w - 2;
    if (hrd(h + 1) != HDR_PAT) return ST_CORRUPT;
    tv = hrd(h);
    if (!tv[31]) return ST_DOUBLE;
    gw = tag_len(tv, NWORDS - h);
    if (gw == 0) return ST_CORRUPT;
    if (hrd(h + gw - 2) != TRL_PAT) return ST_CORRUPT;
    if (h >= 2) begin
      if (hrd(h - 2) != TRL_PAT) return ST_CORRUPT;
      pw = tag_len(hrd(h - 1), h);
      if (pw == 0) return ST_CORRUPT;
      ph = h - pw;
      if (hrd(ph + 1) != HDR_PAT) return ST_CORRUPT;
      tv = hrd(ph);
      pred_free = !tv[31];
    end
    s = h + gw;
    if (s + 2 <= NWORDS) begin
      if (hrd(s + 1) != HDR_PAT) return ST_CORRUPT;
      tv = hrd(s);
      sw = tag_len(tv, NWORDS - s);
      if (sw == 0) return ST_CORRUPT;
      if (hrd(s + sw - 2) != TRL_PAT) return ST_CORRUPT;
      succ_free = !tv[31];
    end
    // Merge with whichever neighbors are free
    if (!pred_free && !succ_free) begin
      hwr(h, -hrd(h));
      hwr(h + gw - 1, -hrd(h + gw - 1));
    end else if (!pred_free) begin
      sz = 32'((s + sw - h) * WBYTES);
      hwr(h, sz);
      hwr(h + gw - 2, '0);
      hwr(s + 1, '0);
      hwr(s + sw - 1, sz);
    end else if (!succ_free) begin
      sz = 32'((h + gw - ph) * WBYTES);
      hwr(ph, sz);
      hwr(h - 2, '0);
      hwr(h + 1, '0);
      hwr(h + gw - 1, sz);
    end else begin
      sz = 32'((s + sw - ph) * WBYTES);
      hwr(ph, sz);
      hwr(h - 2, '0);
      hwr(h + 1, '0);
      hwr(h + gw - 2, '0);
      hwr(s + 1, '0);
      hwr(s + sw - 1, sz);
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] heap_size(longint w, output logic [13:0] net);
    logic [31:0] m;
    net = '0;
    if (w >= NWORDS || w < 2) return ST_OUTSIDE;
    if (hrd(w - 1) != HDR_PAT) return ST_CORRUPT;
    m = tag_mag(hrd(w - 2));
    m = (m <= 4 * WBYTES) ? 32'd0 : m - 4 * WBYTES;
    net = (m > 16383) ? 14'd16383 : m[13:0];
    return ST_OK;
  endfunction

  function automatic out_item_t heap_step(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.cmd)
      CMD_ALLOC: r.status = heap_alloc(it.req_bytes, r.payload_index);
      CMD_FREE:  r.status = heap_free(it.word_index);
      CMD_SIZE:  r.status = heap_size(it.word_index, r.net_bytes);
      CMD_WRITE: hwr(it.word_index, it.write_value);
      CMD_READ:  r.read_value = hrd(it.word_index);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    err_count++;
  endtask

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item), 64'd0);
      end else begin
        want = pending_q.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 64'(out_item.status), 64'(want.status));
        if (out_item.payload_index !== want.payload_index)
          report_mismatch("payload_index", 64'(out_item.payload_index),
                          64'(want.payload_index));
        if (out_item.net_bytes !== want.net_bytes)
          report_mismatch("net_bytes", 64'(out_item.net_bytes), 64'(want.net_bytes));
        if (out_item.read_value !== want.read_value)
          report_mismatch("read_value", 64'(out_item.read_value), 64'(want.read_value));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Timeout at cycle %0d", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Predict first; commands that would read an undefined word are dropped
  task automatic send_cmd(in_item_t it, int gap, output bit sent);
    out_item_t r;
    snap_mem = heap_mem;
    snap_set = heap_set;
    blank_read = 1'b0;
    r = heap_step(it);
    sent = !blank_read;
    if (!sent) begin
      heap_mem = snap_mem;
      heap_set = snap_set;
      return;
    end
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    in_item = it;
    start = 1'b1;
    pending_q.push_back(r);
    @(negedge clk);
    start = 1'b0;
    sent_count++;
    status_seen[r.status]++;
    if (it.cmd == CMD_ALLOC && r.status == ST_OK) live_q.push_back(r.payload_index);
    if (it.cmd == CMD_FREE && r.status == ST_OK) begin
      foreach (live_q[i]) if (live_q[i] == it.word_index) begin
        live_q.delete(i);
        break;
      end
      freed_q.push_back(it.word_index);
      if (freed_q.size() > 16) void'(freed_q.pop_front());
    end
  endtask

  function automatic in_item_t mk(logic [2:0] c, logic [13:0] rq, logic [11:0] wi,
                                  logic [31:0] wv);
    in_item_t it;
    it.cmd = c; it.req_bytes = rq; it.word_index = wi; it.write_value = wv;
    return it;
  endfunction

  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Extremes, each command, edge statuses, corruption, lone free and two merge cases
  task automatic test_directed();
    bit ok;
    logic [11:0] a, b, c;
    logic [31:0] keep;
    send_cmd(mk(CMD_READ, 0, 0, 0), 0, ok);
    send_cmd(mk(CMD_READ, 0, 12'd4095, 0), 0, ok);
    send_cmd(mk(CMD_SIZE, 0, 12'd2, 0), 0, ok);
    send_cmd(mk(CMD_SIZE, 0, 12'd1, 0), 0, ok);
    send_cmd(mk(CMD_FREE, 0, 12'd0, 0), 0, ok);
    send_cmd(mk(CMD_ALLOC, 14'd0, 0, 0), 0, ok);
    send_cmd(mk(CMD_ALLOC, 14'd16383, 0, 0), 0, ok);
    send_cmd(mk(CMD_SPARE5, 14'h3fff, 12'hfff, '1), 0, ok);
    send_cmd(mk(CMD_SPARE6, 0, 0, 0), 0, ok);
    send_cmd(mk(CMD_SPARE7, 0, 0, 0), 0, ok);
    send_cmd(mk(CMD_ALLOC, 14'd1, 0, 0), 0, ok);
    a = live_q[$];
    send_cmd(mk(CMD_ALLOC, 14'd37, 0, 0), 0, ok);
    b = live_q[$];
    send_cmd(mk(CMD_ALLOC, 14'd8, 0, 0), 0, ok);
    c = live_q[$];
    send_cmd(mk(CMD_WRITE, 0, b, '1), 0, ok);
    send_cmd(mk(CMD_READ, 0, b, 0), 0, ok);
    send_cmd(mk(CMD_SIZE, 0, b, 0), 0, ok);
    // Broken header pattern, then repaired
    send_cmd(mk(CMD_WRITE, 0, b - 1, 32'h0), 0, ok);
    send_cmd(mk(CMD_FREE, 0, b, 0), 0, ok);
    send_cmd(mk(CMD_WRITE, 0, b - 1, HDR_PAT), 0, ok);
    // Misaligned first tag stops the walk
    keep = heap_mem[0];
    send_cmd(mk(CMD_WRITE, 0, 0, 32'd5), 0, ok);
    send_cmd(mk(CMD_ALLOC, 14'd4, 0, 0), 0, ok);
    send_cmd(mk(CMD_WRITE, 0, 0, keep), 0, ok);
    // Lone free, double free, merge with successor, then with both neighbors
    send_cmd(mk(CMD_FREE, 0, b, 0), 0, ok);
    send_cmd(mk(CMD_FREE, 0, b, 0), 0, ok);
    send_cmd(mk(CMD_FREE, 0, a, 0), 0, ok);
    send_cmd(mk(CMD_FREE, 0, c, 0), 0, ok);
    drain();
  endtask

  // Random commands, mostly valid traffic over the live blocks
  task automatic test_random(int n_items);
    in_item_t it;
    bit ok;
    int pick, gap, k;
    logic [11:0] hdl;
    longint gw;
    while (n_items > 0) begin
      pick = $urandom_range(99);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10);
      it = mk(CMD_ALLOC, 0, 0, 0);
      if (live_q.size() > 50 && pick < 30) pick = 40;
      if (pick < 30) begin
        k = $urandom_range(99);
        it.req_bytes = (k < 2) ? 14'd0 : (k < 10) ? 14'($urandom_range(16383))
                                                 : 14'($urandom_range(1, 300));
      end else if (pick < 56 && live_q.size() != 0) begin
        it.cmd = CMD_FREE;
        it.word_index = live_q[$urandom_range(live_q.size() - 1)];
      end else if (pick < 62) begin
        it.cmd = CMD_FREE;
        it.word_index = (freed_q.size() != 0 && pick < 59)
                        ? freed_q[$urandom_range(freed_q.size() - 1)]
                        : 12'($urandom_range(NWORDS - 1));
      end else if (pick < 72) begin
        it.cmd = CMD_SIZE;
        it.word_index = (live_q.size() != 0 && pick < 69)
                        ? live_q[$urandom_range(live_q.size() - 1)]
                        : 12'($urandom_range(NWORDS - 1));
      end else if (pick < 86 && live_q.size() != 0) begin
        // Payload write inside a live block
        hdl = live_q[$urandom_range(live_q.size() - 1)];
        gw = tag_mag(heap_mem[hdl - 2]) / WBYTES;
        it.cmd = CMD_WRITE;
        it.word_index = hdl + 12'($urandom_range(32'(gw - 5)));
        it.write_value = $urandom();
      end else begin
        it.cmd = CMD_READ;
        for (k = 0; k < 40; k++) begin
          it.word_index = 12'($urandom_range(NWORDS - 1));
          if (heap_set[it.word_index]) break;
        end
      end
      send_cmd(it, gap, ok);
      if (ok) n_items--;
      if (ok && n_items % 150 == 0) drain();
    end
    drain();
  endtask

  // Free everything still live so the heap merges back to one block
  task automatic test_release_all();
    bit ok;
    while (live_q.size() != 0)
      send_cmd(mk(CMD_FREE, 0, live_q[$urandom_range(live_q.size() - 1)], 0),
               $urandom_range(10), ok);
    send_cmd(mk(CMD_READ, 0, 0, 0), 0, ok);
    send_cmd(mk(CMD_SIZE, 0, 12'd2, 0), 0, ok);
    drain();
  endtask

  initial begin
    foreach (heap_mem[i]) begin
      heap_mem[i] = '0;
      heap_set[i] = 1'b0;
    end
    hwr(0, NWORDS * WBYTES);
    hwr(1, HDR_PAT);
    hwr(NWORDS - 2, TRL_PAT);
    hwr(NWORDS - 1, NWORDS * WBYTES);
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(900);
    test_release_all();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d commands: ok %0d, no memory %0d, outside %0d, corrupt %0d,",
             sent_count, status_seen[ST_OK], status_seen[ST_NOMEM],
             status_seen[ST_OUTSIDE], status_seen[ST_CORRUPT]);
    $display("double free %0d, zero size %0d; %0d mismatches",
             status_seen[ST_DOUBLE], status_seen[ST_ZERO], err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
